### src/pnmhp_pkg.sv
// ============================================================================
// pnmhp_pkg
// Types and character codes shared by the PNM header parser modules.
// ============================================================================
package pnmhp_pkg;

    localparam int FIELD_BITS = 16;

    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_4     = 8'h34;  // '4'
    localparam logic [7:0] CH_5     = 8'h35;  // '5'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic KIND_BITMAP = 1'b0;
    localparam logic KIND_GREY   = 1'b1;

    typedef struct packed {
        logic                  status;
        logic                  image_kind;
        logic [FIELD_BITS-1:0] width;
        logic [FIELD_BITS-1:0] height;
        logic [FIELD_BITS-1:0] max_grey;
    } t_result;

endpackage

### src/pnm_header_parser_unit.sv
// ============================================================================
// pnm_header_parser_unit
// Header parser for binary PBM (P4) and PGM (P5) images, one byte per
// transaction, giving one result per header.
// ============================================================================
// The unit takes one header byte in every clock cycle in which tready is high.
// Each byte is handled in the cycle the parser state machine accepts it; any
// result is registered in the output register, or in the skid register while
// the output stalls. The two-entry output buffer drops tready only when two
// results wait; as a header yields a single result, the input normally runs
// at one transaction per cycle. VALUE_BITS sets the saturation limit of the decimal
// values (2^VALUE_BITS-1); the result fields carry its low 16 bits.
module pnm_header_parser_unit #(
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_axis_tuser,   // [0] end_of_data, [1] restart
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] width, [31:16] height, [47:32] max_grey
    output logic [1:0]  o_m_axis_tuser    // [0] status, [1] image_kind
);
    import pnmhp_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    pnmhp_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_data_byte   (i_s_axis_tdata),
        .i_end_of_data (i_s_axis_tuser[0]),
        .i_restart     (i_s_axis_tuser[1]),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    pnmhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_res   (w_res),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out)
    );

    assign o_m_axis_tdata = {w_out.max_grey, w_out.height, w_out.width};
    assign o_m_axis_tuser = {w_out.image_kind, w_out.status};

endmodule

### src/pnmhp_parser.sv
// ============================================================================
// pnmhp_parser
// Per-byte header state machine: magic check, decimal number accumulation
// with saturation, comment skipping and result generation.
// ============================================================================
module pnmhp_parser #(
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_data,
    input  logic               i_restart,
    output logic               o_res_valid,
    output pnmhp_pkg::t_result o_res
);
    import pnmhp_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC0  = 3'd0,
        PH_MAGIC1  = 3'd1,
        PH_WIDTH   = 3'd2,
        PH_HEIGHT  = 3'd3,
        PH_MAXGRAY = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    t_phase                r_phase, n_phase;
    logic                  r_magic_bad, n_magic_bad;
    logic                  r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_seen, n_seen;
    logic                  r_comment, n_comment;
    logic [VALUE_BITS-1:0] r_width, n_width;
    logic [VALUE_BITS-1:0] r_height, n_height;

    logic [VALUE_BITS+3:0] w_prod;

    // Narrow or widen a stored value to the fixed result field width.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+FIELD_BITS-1:0] t;
        t = {{FIELD_BITS{1'b0}}, v};
        return t[FIELD_BITS-1:0];
    endfunction

    // acc * 10 + digit as two shifts and adds.
    assign w_prod = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                  + {{VALUE_BITS{1'b0}}, i_data_byte[3:0]};

    always_comb begin
        n_phase     = r_phase;
        n_magic_bad = r_magic_bad;
        n_kind      = r_kind;
        n_acc       = r_acc;
        n_seen      = r_seen;
        n_comment   = r_comment;
        n_width     = r_width;
        n_height    = r_height;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.status = STATUS_ERR;

        if (i_valid) begin
            if (i_restart) begin
                n_phase     = PH_MAGIC0;
                n_magic_bad = 1'b0;
                n_kind      = KIND_BITMAP;
                n_acc       = '0;
                n_seen      = 1'b0;
                n_comment   = 1'b0;
                n_width     = '0;
                n_height    = '0;
            end else if (r_phase == PH_MAGIC0 || r_phase == PH_MAGIC1 ||
                         r_phase == PH_WIDTH || r_phase == PH_HEIGHT ||
                         r_phase == PH_MAXGRAY) begin
                if (i_end_of_data) begin
                    o_res_valid = 1'b1;
                    n_phase     = PH_DONE;
                end else begin
                    case (r_phase)
                        PH_MAGIC0: begin
                            n_magic_bad = (i_data_byte != CH_P);
                            n_phase     = PH_MAGIC1;
                        end
                        PH_MAGIC1: begin
                            if (!r_magic_bad && (i_data_byte == CH_4 ||
                                                 i_data_byte == CH_5)) begin
                                n_kind    = (i_data_byte == CH_5) ? KIND_GREY : KIND_BITMAP;
                                n_phase   = PH_WIDTH;
                                n_acc     = '0;
                                n_seen    = 1'b0;
                                n_comment = 1'b0;
                            end else begin
                                o_res_valid = 1'b1;
                                n_phase     = PH_DONE;
                            end
                        end
                        default: begin
                            case (i_data_byte) inside
                                CH_HASH: begin
                                    n_comment = 1'b1;
                                end
                                CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                                    if (i_data_byte == CH_CR || i_data_byte == CH_LF) begin
                                        n_comment = 1'b0;
                                    end
                                    // The number ends only outside a comment,
                                    // judged on the flag before this byte.
                                    if (!r_comment && r_seen) begin
                                        if (r_acc == '0) begin
                                            o_res_valid = 1'b1;
                                            n_phase     = PH_DONE;
                                        end else if (r_phase == PH_WIDTH) begin
                                            n_width   = r_acc;
                                            n_phase   = PH_HEIGHT;
                                            n_acc     = '0;
                                            n_seen    = 1'b0;
                                            n_comment = 1'b0;
                                        end else if (r_phase == PH_HEIGHT &&
                                                     r_kind == KIND_GREY) begin
                                            n_height  = r_acc;
                                            n_phase   = PH_MAXGRAY;
                                            n_acc     = '0;
                                            n_seen    = 1'b0;
                                            n_comment = 1'b0;
                                        end else begin
                                            o_res_valid      = 1'b1;
                                            n_phase          = PH_DONE;
                                            o_res.status     = STATUS_OK;
                                            o_res.image_kind = r_kind;
                                            o_res.width      = to_field(r_width);
                                            if (r_phase == PH_HEIGHT) begin
                                                n_height       = r_acc;
                                                o_res.height   = to_field(r_acc);
                                                o_res.max_grey = FIELD_BITS'(1);
                                            end else begin
                                                o_res.height   = to_field(r_height);
                                                o_res.max_grey = to_field(r_acc);
                                            end
                                        end
                                    end
                                end
                                [CH_ZERO:CH_NINE]: begin
                                    if (!r_comment) begin
                                        if (w_prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
                                            n_acc = VALUE_MAX;
                                        end else begin
                                            n_acc = w_prod[VALUE_BITS-1:0];
                                        end
                                        n_seen = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC0;
            r_magic_bad <= 1'b0;
            r_kind      <= KIND_BITMAP;
            r_acc       <= '0;
            r_seen      <= 1'b0;
            r_comment   <= 1'b0;
            r_width     <= '0;
            r_height    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_magic_bad <= n_magic_bad;
            r_kind      <= n_kind;
            r_acc       <= n_acc;
            r_seen      <= n_seen;
            r_comment   <= n_comment;
            r_width     <= n_width;
            r_height    <= n_height;
        end
    end

endmodule

### src/pnmhp_out_buf.sv
// ============================================================================
// pnmhp_out_buf
// Two-entry result buffer: an output register backed by a skid register,
// so the input side keeps taking bytes while a result waits.
// ============================================================================
module pnmhp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pnmhp_pkg::t_result i_res,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output pnmhp_pkg::t_result o_res
);
    import pnmhp_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_res;
                n_out_valid = i_valid;
            end
        end else if (i_valid) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule
